FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the line parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/amclp_pkg.sv
// Shared types and constants of the ASCII motor command line parser
package amclp_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int MAX_DIGITS_DEF    = 6;
    localparam int VAL_W             = 21;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;

    localparam logic [31:0] WORD_DUTY = "duty";
    localparam logic [31:0] WORD_STOP = "stop";
    localparam logic [23:0] WORD_VEL  = "vel";
    localparam logic [23:0] WORD_SPD  = "spd";

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CMD    = 2'd1,
        EV_REJECT = 2'd2
    } evt_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_DUTY = 3'd1,
        KIND_VEL  = 3'd2,
        KIND_SPD  = 3'd3,
        KIND_STOP = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_PARSE,
        TS_EMIT
    } top_st_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_PREFIX,
        SC_DECIDE,
        SC_SPACE,
        SC_SIGN,
        SC_DIGIT,
        SC_TAIL,
        SC_DONE
    } scan_st_t;

    typedef struct packed {
        logic                    done;
        kind_t                   kind;
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;
    } scan_res_t;

endpackage

FILE: rtl/core/amclp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module amclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/amclp_scan.sv
// Line scanner: walks the stored line byte by byte and decodes the command
module amclp_scan #(
    parameter int LINE_CAPACITY = amclp_pkg::LINE_CAPACITY_DEF,
    parameter int MAX_DIGITS    = amclp_pkg::MAX_DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [$clog2(LINE_CAPACITY)-1:0]     len,
    output logic [$clog2(LINE_CAPACITY-1)-1:0]   rd_addr,
    input  logic [7:0]                           rd_data,
    output amclp_pkg::scan_res_t                 res
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY);
    localparam int ADDR_W = $clog2(LINE_CAPACITY - 1);
    localparam int MAG_W  = $clog2(10 ** MAX_DIGITS);
    localparam int DIG_W  = $clog2(MAX_DIGITS + 1);
    localparam int VAL_W  = amclp_pkg::VAL_W;
    localparam int WIDE_W = MAG_W + VAL_W;

    amclp_pkg::scan_st_t state_reg, state_next;
    amclp_pkg::kind_t    kind_reg, kind_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [7:0]          pfx_reg [5];
    logic                num_idx_reg, num_idx_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [DIG_W-1:0]    dig_reg, dig_next;
    logic signed [VAL_W-1:0] left_reg, left_next;
    logic signed [VAL_W-1:0] right_reg, right_next;

    logic [7:0]        ch;
    logic              is_digit, is_space, is_sign;
    logic              dig_full, more_num, spd_ok;
    logic              duty_m, vel_m, spd_m, stop_m;
    logic [MAG_W-1:0]  mag_acc;
    logic [WIDE_W-1:0] mag_wide, val_wide;
    logic signed [VAL_W-1:0] val;

    // Bytes past the stored length read as the end of text
    assign ch       = (pos_reg < len_reg) ? rd_data : amclp_pkg::CH_NUL;
    assign is_digit = (ch >= amclp_pkg::CH_DIG0) && (ch <= amclp_pkg::CH_DIG9);
    assign is_space = (ch == amclp_pkg::CH_SPACE);
    assign is_sign  = (ch == amclp_pkg::CH_MINUS) || (ch == amclp_pkg::CH_PLUS);
    assign dig_full = (dig_reg == DIG_W'(MAX_DIGITS));
    assign more_num = !num_idx_reg && (kind_reg != amclp_pkg::KIND_SPD);
    assign spd_ok   = (mag_reg == '0) || ((mag_reg == MAG_W'(1)) && !neg_reg);

    assign mag_acc  = (mag_reg << 3) + (mag_reg << 1) + MAG_W'(ch[3:0]);
    assign mag_wide = WIDE_W'(mag_reg);
    assign val_wide = neg_reg ? -mag_wide : mag_wide;
    assign val      = val_wide[VAL_W-1:0];

    assign duty_m = ({pfx_reg[0], pfx_reg[1], pfx_reg[2], pfx_reg[3]} == amclp_pkg::WORD_DUTY)
                    && ((pfx_reg[4] == amclp_pkg::CH_SPACE) || (pfx_reg[4] == amclp_pkg::CH_NUL));
    assign vel_m  = ({pfx_reg[0], pfx_reg[1], pfx_reg[2]} == amclp_pkg::WORD_VEL)
                    && ((pfx_reg[3] == amclp_pkg::CH_SPACE) || (pfx_reg[3] == amclp_pkg::CH_NUL));
    assign spd_m  = ({pfx_reg[0], pfx_reg[1], pfx_reg[2]} == amclp_pkg::WORD_SPD)
                    && ((pfx_reg[3] == amclp_pkg::CH_SPACE) || (pfx_reg[3] == amclp_pkg::CH_NUL));
    assign stop_m = ({pfx_reg[0], pfx_reg[1], pfx_reg[2], pfx_reg[3]} == amclp_pkg::WORD_STOP)
                    && (pfx_reg[4] == amclp_pkg::CH_NUL);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            amclp_pkg::SC_IDLE:   if (start) state_next = amclp_pkg::SC_PREFIX;
            amclp_pkg::SC_PREFIX: if (pos_reg == LEN_W'(4)) state_next = amclp_pkg::SC_DECIDE;
            amclp_pkg::SC_DECIDE: begin
                if (duty_m || vel_m || spd_m) state_next = amclp_pkg::SC_SPACE;
                else state_next = amclp_pkg::SC_DONE;
            end
            amclp_pkg::SC_SPACE: begin
                if (is_space) state_next = amclp_pkg::SC_SPACE;
                else if (is_sign) state_next = amclp_pkg::SC_SIGN;
                else if (is_digit) state_next = amclp_pkg::SC_DIGIT;
                else state_next = amclp_pkg::SC_DONE;
            end
            amclp_pkg::SC_SIGN: begin
                if (is_digit) state_next = amclp_pkg::SC_DIGIT;
                else state_next = amclp_pkg::SC_DONE;
            end
            amclp_pkg::SC_DIGIT: begin
                if (is_digit) state_next = dig_full ? amclp_pkg::SC_DONE : amclp_pkg::SC_DIGIT;
                else if (more_num) state_next = amclp_pkg::SC_SPACE;
                else if ((kind_reg == amclp_pkg::KIND_SPD) && !spd_ok) begin
                    state_next = amclp_pkg::SC_DONE;
                end else state_next = amclp_pkg::SC_TAIL;
            end
            amclp_pkg::SC_TAIL: if (!is_space) state_next = amclp_pkg::SC_DONE;
            amclp_pkg::SC_DONE: state_next = amclp_pkg::SC_IDLE;
            default:            state_next = amclp_pkg::SC_IDLE;
        endcase
    end

    always_comb begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        num_idx_next = num_idx_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        dig_next     = dig_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        unique case (state_reg)
            amclp_pkg::SC_IDLE: begin
                pos_next     = '0;
                len_next     = len;
                kind_next    = amclp_pkg::KIND_NONE;
                num_idx_next = 1'b0;
                mag_next     = '0;
                neg_next     = 1'b0;
                dig_next     = '0;
                left_next    = '0;
                right_next   = '0;
            end
            amclp_pkg::SC_PREFIX: pos_next = pos_reg + LEN_W'(1);
            amclp_pkg::SC_DECIDE: begin
                if (duty_m) begin
                    kind_next = amclp_pkg::KIND_DUTY;
                    pos_next  = LEN_W'(4);
                end else if (vel_m) begin
                    kind_next = amclp_pkg::KIND_VEL;
                    pos_next  = LEN_W'(3);
                end else if (spd_m) begin
                    kind_next = amclp_pkg::KIND_SPD;
                    pos_next  = LEN_W'(3);
                end else if (stop_m) begin
                    kind_next = amclp_pkg::KIND_STOP;
                end
            end
            amclp_pkg::SC_SPACE: begin
                if (is_space || is_sign) pos_next = pos_reg + LEN_W'(1);
                if (ch == amclp_pkg::CH_MINUS) neg_next = 1'b1;
                if (is_digit) begin
                    pos_next = pos_reg + LEN_W'(1);
                    mag_next = mag_acc;
                    dig_next = dig_reg + DIG_W'(1);
                end
                if (!is_space && !is_sign && !is_digit) kind_next = amclp_pkg::KIND_NONE;
            end
            amclp_pkg::SC_SIGN: begin
                if (is_digit) begin
                    pos_next = pos_reg + LEN_W'(1);
                    mag_next = mag_acc;
                    dig_next = dig_reg + DIG_W'(1);
                end else begin
                    kind_next = amclp_pkg::KIND_NONE;
                end
            end
            amclp_pkg::SC_DIGIT: begin
                if (is_digit) begin
                    if (dig_full) begin
                        kind_next = amclp_pkg::KIND_NONE;
                    end else begin
                        pos_next = pos_reg + LEN_W'(1);
                        mag_next = mag_acc;
                        dig_next = dig_reg + DIG_W'(1);
                    end
                end else if (more_num) begin
                    // Hold the position: the ending byte opens the second number
                    left_next    = val;
                    num_idx_next = 1'b1;
                    mag_next     = '0;
                    neg_next     = 1'b0;
                    dig_next     = '0;
                end else if (kind_reg == amclp_pkg::KIND_SPD) begin
                    if (spd_ok) begin
                        left_next  = val;
                        right_next = val;
                    end else begin
                        kind_next = amclp_pkg::KIND_NONE;
                    end
                end else begin
                    right_next = val;
                end
            end
            amclp_pkg::SC_TAIL: begin
                if (is_space) pos_next = pos_reg + LEN_W'(1);
                else if (ch != amclp_pkg::CH_NUL) kind_next = amclp_pkg::KIND_NONE;
            end
            amclp_pkg::SC_DONE: pos_next = '0;
            default:            pos_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= amclp_pkg::SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        len_reg     <= len_next;
        kind_reg    <= kind_next;
        num_idx_reg <= num_idx_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        dig_reg     <= dig_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        if (state_reg == amclp_pkg::SC_PREFIX) begin
            pfx_reg[0] <= pfx_reg[1];
            pfx_reg[1] <= pfx_reg[2];
            pfx_reg[2] <= pfx_reg[3];
            pfx_reg[3] <= pfx_reg[4];
            pfx_reg[4] <= ch;
        end
    end

    // Registered RAM read: address the byte the next cycle works on
    assign rd_addr = pos_next[ADDR_W-1:0];

    always_comb begin
        res.done      = (state_reg == amclp_pkg::SC_DONE);
        res.kind      = kind_reg;
        res.left_val  = (kind_reg != amclp_pkg::KIND_NONE) ? left_reg : '0;
        res.right_val = (kind_reg != amclp_pkg::KIND_NONE) ? right_reg : '0;
    end

endmodule

FILE: rtl/core/ascii_motor_command_line_parser_top.sv
// Top level of the ASCII motor command line parser
`include "assert_macros.svh"

// Takes one received byte per item and returns exactly one result item per
// byte. An ordinary byte is stored in the line memory; the accepting edge
// updates the line and the pending result, and the output register is loaded
// from the pending result once it is free or m_ready is high. A CR or LF ends
// the line: an empty or overflowed line gives its result the same way, while
// a stored line is scanned through the line memory's single read port: the
// scanner reads the first five bytes as the command word, decides on the
// command, walks the argument bytes and then finishes.
// Only one item is in work at a time; s_ready drops while an item is in work,
// but a finished result may wait in the output register for m_ready while the
// next byte is already taken. The line memory needs no clearing after reset:
// only bytes written in the current line are ever read. Lines of more than
// LINE_CAPACITY-1 bytes are dropped and reported as rejected at their line end.
module ascii_motor_command_line_parser_top #(
    parameter int LINE_CAPACITY = amclp_pkg::LINE_CAPACITY_DEF,
    parameter int MAX_DIGITS    = amclp_pkg::MAX_DIGITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_event_res,
    output logic [2:0]                          m_command_kind,
    output logic signed [amclp_pkg::VAL_W-1:0]  m_left_value,
    output logic signed [amclp_pkg::VAL_W-1:0]  m_right_value,
    output logic [15:0]                         m_rejected_lines,
    output logic [15:0]                         m_overflowed_lines
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY);
    localparam int ADDR_W = $clog2(LINE_CAPACITY - 1);
    localparam int VAL_W  = amclp_pkg::VAL_W;

    amclp_pkg::top_st_t state_reg, state_next;

    // Line bookkeeping and running counters
    logic [LEN_W-1:0] len_reg, len_next;
    logic             discard_reg, discard_next;
    logic [15:0]      rej_reg, rej_next;
    logic [15:0]      ovf_reg, ovf_next;

    // Result waiting to be loaded into the output register
    amclp_pkg::evt_t         res_ev_reg, res_ev_next;
    amclp_pkg::kind_t        res_kind_reg, res_kind_next;
    logic signed [VAL_W-1:0] res_left_reg, res_left_next;
    logic signed [VAL_W-1:0] res_right_reg, res_right_next;

    // Output register
    logic                    m_valid_reg;
    logic [1:0]              m_ev_reg;
    logic [2:0]              m_kind_reg;
    logic signed [VAL_W-1:0] m_left_reg, m_right_reg;
    logic [15:0]             m_rej_reg, m_ovf_reg;

    logic accept, is_eol, line_full;
    logic scan_start, ram_we, out_load;

    logic [ADDR_W-1:0]    rd_addr;
    logic [7:0]           rd_data;
    amclp_pkg::scan_res_t scan_res;

    assign accept    = s_valid && s_ready;
    assign is_eol    = (s_rx_byte == amclp_pkg::CH_LF) || (s_rx_byte == amclp_pkg::CH_CR);
    assign line_full = (len_reg >= LEN_W'(LINE_CAPACITY - 1));

    // Line memory: written as bytes arrive, read back by the scanner
    amclp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY - 1)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (s_rx_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    amclp_scan #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .MAX_DIGITS    (MAX_DIGITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .len     (len_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (scan_res)
    );

    // Next state: take a byte, scan a finished line, then hand the result over
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            amclp_pkg::TS_IDLE: begin
                if (accept) begin
                    if (is_eol && !discard_reg && (len_reg != '0)) begin
                        state_next = amclp_pkg::TS_PARSE;
                    end else begin
                        state_next = amclp_pkg::TS_EMIT;
                    end
                end
            end
            amclp_pkg::TS_PARSE: if (scan_res.done) state_next = amclp_pkg::TS_EMIT;
            amclp_pkg::TS_EMIT:  if (!m_valid_reg || m_ready) state_next = amclp_pkg::TS_IDLE;
            default:             state_next = amclp_pkg::TS_IDLE;
        endcase
    end

    // Control outputs of the state machine
    always_comb begin
        s_ready    = 1'b0;
        scan_start = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            amclp_pkg::TS_IDLE: begin
                s_ready    = 1'b1;
                scan_start = accept && is_eol && !discard_reg && (len_reg != '0);
                ram_we     = accept && !is_eol && !discard_reg && !line_full;
            end
            amclp_pkg::TS_PARSE: ;
            amclp_pkg::TS_EMIT:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // Line bookkeeping and the pending result
    always_comb begin
        len_next       = len_reg;
        discard_next   = discard_reg;
        rej_next       = rej_reg;
        ovf_next       = ovf_reg;
        res_ev_next    = res_ev_reg;
        res_kind_next  = res_kind_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        if ((state_reg == amclp_pkg::TS_IDLE) && accept) begin
            res_ev_next    = amclp_pkg::EV_NONE;
            res_kind_next  = amclp_pkg::KIND_NONE;
            res_left_next  = '0;
            res_right_next = '0;
            if (is_eol) begin
                discard_next = 1'b0;
                // An overflowed line is rejected at its end; an empty one gives no event
                if (discard_reg) begin
                    len_next    = '0;
                    rej_next    = rej_reg + 16'd1;
                    res_ev_next = amclp_pkg::EV_REJECT;
                end
            end else if (!discard_reg) begin
                if (line_full) begin
                    // Drop the line and ignore bytes up to the line end
                    discard_next = 1'b1;
                    ovf_next     = ovf_reg + 16'd1;
                    len_next     = '0;
                end else begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
        if ((state_reg == amclp_pkg::TS_PARSE) && scan_res.done) begin
            len_next = '0;
            if (scan_res.kind != amclp_pkg::KIND_NONE) begin
                res_ev_next    = amclp_pkg::EV_CMD;
                res_kind_next  = scan_res.kind;
                res_left_next  = scan_res.left_val;
                res_right_next = scan_res.right_val;
            end else begin
                rej_next    = rej_reg + 16'd1;
                res_ev_next = amclp_pkg::EV_REJECT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= amclp_pkg::TS_IDLE;
            len_reg     <= '0;
            discard_reg <= 1'b0;
            rej_reg     <= '0;
            ovf_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            discard_reg <= discard_next;
            rej_reg     <= rej_next;
            ovf_reg     <= ovf_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_ev_reg    <= res_ev_next;
        res_kind_reg  <= res_kind_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        if (out_load) begin
            m_ev_reg    <= res_ev_reg;
            m_kind_reg  <= res_kind_reg;
            m_left_reg  <= res_left_reg;
            m_right_reg <= res_right_reg;
            m_rej_reg   <= rej_reg;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_res        = m_ev_reg;
    assign m_command_kind     = m_kind_reg;
    assign m_left_value       = m_left_reg;
    assign m_right_value      = m_right_reg;
    assign m_rejected_lines   = m_rej_reg;
    assign m_overflowed_lines = m_ovf_reg;

    `ASSERT_IMPLIES(a_done_in_parse, scan_res.done, state_reg == amclp_pkg::TS_PARSE, "scan finished outside a parse")
    `ASSERT_ALWAYS(a_len_bound, len_reg <= LEN_W'(LINE_CAPACITY - 1), "line length beyond the store")
    `ASSERT_IMPLIES(a_discard_empty, discard_reg, len_reg == '0, "discarded line still holds bytes")
    `ASSERT_NEXT(a_load_valid, out_load, m_valid_reg, "loaded result not presented")

endmodule

FILE: test/tb_top.sv
// Testbench for the ASCII motor command line parser: directed and random lines
`timescale 1ns / 100ps

module tb_top;

    localparam int STORE_DEPTH = amclp_pkg::LINE_CAPACITY_DEF - 1;

    // One result item as the block reports it
    typedef struct {
        logic [1:0]  ev;
        logic [2:0]  kind;
        logic [20:0] left;
        logic [20:0] right;
        logic [15:0] rejects;
        logic [15:0] overflows;
    } parse_res_t;

    // Line predictor and store of expected results
    class line_scoreboard;
        logic [7:0]  line_buf[STORE_DEPTH];
        int          line_len;
        bit          discarding;
        logic [15:0] reject_cnt;
        logic [15:0] overflow_cnt;
        parse_res_t  pending[$];
        int          errors;

        function new();
            line_len = 0;
            discarding = 0;
            reject_cnt = 0;
            overflow_cnt = 0;
            errors = 0;
        endfunction

        // Character at a position of the line; zero past the stored length
        function logic [7:0] char_at(int i);
            if (i < line_len)
                return line_buf[i];
            return amclp_pkg::CH_NUL;
        endfunction

        function bit word_at_start(string w);
            logic [7:0] f;
            for (int i = 0; i < w.len(); i++)
                if (char_at(i) != w[i])
                    return 0;
            f = char_at(w.len());
            return f == amclp_pkg::CH_SPACE || f == amclp_pkg::CH_NUL;
        endfunction

        function bit take_number(inout int pos, output longint val);
            int     i;
            longint mag;
            bit     neg;
            int     digits;
            i = pos;
            mag = 0;
            neg = 0;
            digits = 0;
            val = 0;
            while (char_at(i) == amclp_pkg::CH_SPACE)
                i++;
            if (char_at(i) == amclp_pkg::CH_MINUS) begin
                neg = 1;
                i++;
            end else if (char_at(i) == amclp_pkg::CH_PLUS) begin
                i++;
            end
            while (char_at(i) >= amclp_pkg::CH_DIG0 && char_at(i) <= amclp_pkg::CH_DIG9) begin
                if (digits >= amclp_pkg::MAX_DIGITS_DEF)
                    return 0;
                mag = mag * 10 + (char_at(i) - amclp_pkg::CH_DIG0);
                i++;
                digits++;
            end
            if (digits == 0)
                return 0;
            val = neg ? -mag : mag;
            pos = i;
            return 1;
        endfunction

        function bit blank_to_end(int i);
            while (char_at(i) == amclp_pkg::CH_SPACE)
                i++;
            return char_at(i) == amclp_pkg::CH_NUL;
        endfunction

        // Decode the finished line; KIND_NONE on a failed match
        function amclp_pkg::kind_t decode_line(output longint a, output longint b);
            int pos;
            bit is_vel;
            a = 0;
            b = 0;
            if (word_at_start("duty") || word_at_start("vel")) begin
                is_vel = char_at(0) == "v";
                pos = is_vel ? 3 : 4;
                if (!take_number(pos, a) || !take_number(pos, b) || !blank_to_end(pos)) begin
                    a = 0;
                    b = 0;
                    return amclp_pkg::KIND_NONE;
                end
                return is_vel ? amclp_pkg::KIND_VEL : amclp_pkg::KIND_DUTY;
            end
            if (word_at_start("spd")) begin
                pos = 3;
                if (!take_number(pos, a) || !blank_to_end(pos) || (a != 0 && a != 1)) begin
                    a = 0;
                    return amclp_pkg::KIND_NONE;
                end
                b = a;
                return amclp_pkg::KIND_SPD;
            end
            if (char_at(0) == "s" && char_at(1) == "t" && char_at(2) == "o" &&
                char_at(3) == "p" && char_at(4) == amclp_pkg::CH_NUL)
                return amclp_pkg::KIND_STOP;
            return amclp_pkg::KIND_NONE;
        endfunction

        function void note_byte(logic [7:0] c);
            parse_res_t        r;
            longint            a, b;
            amclp_pkg::kind_t  k;
            r.ev = amclp_pkg::EV_NONE;
            r.kind = amclp_pkg::KIND_NONE;
            a = 0;
            b = 0;
            if (c == amclp_pkg::CH_LF || c == amclp_pkg::CH_CR) begin
                if (discarding) begin
                    discarding = 0;
                    line_len = 0;
                    reject_cnt++;
                    r.ev = amclp_pkg::EV_REJECT;
                end else if (line_len != 0) begin
                    k = decode_line(a, b);
                    line_len = 0;
                    r.kind = k;
                    if (k != amclp_pkg::KIND_NONE) begin
                        r.ev = amclp_pkg::EV_CMD;
                    end else begin
                        reject_cnt++;
                        r.ev = amclp_pkg::EV_REJECT;
                    end
                end
            end else if (!discarding) begin
                if (line_len >= STORE_DEPTH) begin
                    discarding = 1;
                    overflow_cnt++;
                    line_len = 0;
                end else begin
                    line_buf[line_len] = c;
                    line_len++;
                end
            end
            r.left = a[20:0];
            r.right = b[20:0];
            r.rejects = reject_cnt;
            r.overflows = overflow_cnt;
            pending.push_back(r);
        endfunction

        function void check_result(parse_res_t got);
            parse_res_t w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result ev=%0d", $time, got.ev);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.ev !== w.ev || got.kind !== w.kind || got.left !== w.left ||
                got.right !== w.right || got.rejects !== w.rejects ||
                got.overflows !== w.overflows) begin
                $display("%0t: expected ev=%0d kind=%0d l=%0d r=%0d rej=%0d ovf=%0d",
                         $time, w.ev, w.kind, $signed(w.left), $signed(w.right),
                         w.rejects, w.overflows);
                $display("%0t: actual   ev=%0d kind=%0d l=%0d r=%0d rej=%0d ovf=%0d",
                         $time, got.ev, got.kind, $signed(got.left), $signed(got.right),
                         got.rejects, got.overflows);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_res;
    logic [2:0]  m_command_kind;
    logic signed [amclp_pkg::VAL_W-1:0] m_left_value;
    logic signed [amclp_pkg::VAL_W-1:0] m_right_value;
    logic [15:0] m_rejected_lines;
    logic [15:0] m_overflowed_lines;

    line_scoreboard sb;
    int  send_idle_pct;   // sender idle chance in percent
    int  recv_idle_pct;   // receiver stall chance in percent
    int  hold_off_cycles; // long receiver hold-off, counted down in the sink
    int  byte_count;

    ascii_motor_command_line_parser_top u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_command_kind     (m_command_kind),
        .m_left_value       (m_left_value),
        .m_right_value      (m_right_value),
        .m_rejected_lines   (m_rejected_lines),
        .m_overflowed_lines (m_overflowed_lines)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Sink: stall at random or through a long hold-off; check every accepted item
    always @(posedge aclk) begin
        parse_res_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.ev = m_event_res;
                got.kind = m_command_kind;
                got.left = m_left_value;
                got.right = m_right_value;
                got.rejects = m_rejected_lines;
                got.overflows = m_overflowed_lines;
                sb.check_result(got);
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte, idling first at random; return once it is taken
    task automatic send_byte(logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= c;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_byte(c);
        byte_count++;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    task automatic send_line(string txt);
        send_text(txt);
        send_byte($urandom_range(1) ? amclp_pkg::CH_LF : amclp_pkg::CH_CR);
    endtask

    // Drop valid, then wait until every expected result has come
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
    endtask

    function automatic string rand_number(int max_digits);
        string s;
        int    n;
        case ($urandom_range(3))
            0: s = "-";
            1: s = "+";
            default: s = "";
        endcase
        n = $urandom_range(max_digits, 1);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(amclp_pkg::CH_DIG0 + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_spaces(int lo);
        string s;
        s = "";
        repeat ($urandom_range(2, lo)) s = {s, " "};
        return s;
    endfunction

    // Mostly well-formed command lines with random content; some broken ones
    function automatic string rand_line();
        string s;
        string arg;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            if ($urandom_range(1))
                s = "duty";
            else
                s = "vel";
            s = {s, rand_spaces(1), rand_number(pick < 3 ? 7 : 6), rand_spaces(1),
                 rand_number(6), rand_spaces(0)};
        end else if (pick < 45) begin
            if ($urandom_range(3) == 0)
                arg = rand_number(2);
            else if ($urandom_range(1))
                arg = "1";
            else
                arg = "0";
            s = {"spd", rand_spaces(1), arg, rand_spaces(0)};
        end else if (pick < 55) begin
            if ($urandom_range(3) == 0)
                s = "stop ";
            else
                s = "stop";
        end else if (pick < 70) begin
            s = {"vel", rand_spaces(1), rand_number(6)};
            if ($urandom_range(1))
                s = {s, "x"};
            else
                s = {s, " 5"};
        end else begin
            // Noise: random bytes, never a line end
            s = "";
            repeat ($urandom_range(pick < 75 ? 40 : 12, 1)) begin
                logic [7:0] c;
                c = 8'($urandom_range(255));
                if (c == amclp_pkg::CH_LF || c == amclp_pkg::CH_CR)
                    c = 8'h20;
                s = {s, string'(c)};
            end
        end
        return s;
    endfunction

    initial begin
        #400000;
        $display("ascii_motor_command_line_parser_top: mismatch");
        $finish;
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        m_ready = 1'b0;
        hold_off_cycles = 0;
        byte_count = 0;
        send_idle_pct = 34;
        recv_idle_pct = 50;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: each command, its edges, empty lines, overflow, zero byte
        send_line("duty 999999 -999999");
        send_line("vel  +0   -1  ");
        send_line("spd 1");
        send_line("spd 0   ");
        send_line("stop");
        send_line("stop ");
        send_line("duty 1234567 1");
        send_line("vel - 1 2");
        send_line("spd 2");
        send_text("duty 1 2");
        send_byte(amclp_pkg::CH_CR);
        send_byte(amclp_pkg::CH_LF);
        send_text("stop");
        send_byte(amclp_pkg::CH_NUL);
        send_line("xx");
        send_text("vel 3 4 ");
        send_byte(amclp_pkg::CH_NUL);
        send_line("junk");
        send_line({8'hFF, 8'h80, 8'h7F});
        send_line("0123456789012345678901234567890");
        send_line("0123456789012345678901234567890X");
        send_line("velocity 1 2");
        drain();

        // Long receiver hold-off while the sender keeps offering bytes
        hold_off_cycles = 300;
        send_line("duty -5 7");
        send_line("vel 3 4");

        // Random phases; the sender pauses until every result is in between them
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 34 : ph == 1 ? 50 : 0;
            recv_idle_pct = ph == 0 ? 50 : ph == 1 ? 34 : 0;
            while (byte_count < 150 * (ph + 1) + 200) begin
                if ($urandom_range(9) == 0) begin
                    // A zero byte ends the text; what follows it is not seen
                    send_text(rand_line());
                    send_byte(amclp_pkg::CH_NUL);
                    send_line("junk");
                end else begin
                    send_line(rand_line());
                end
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ascii_motor_command_line_parser_top: match");
        else
            $display("ascii_motor_command_line_parser_top: mismatch");
        $finish;
    end
endmodule
